>>> design/jct_pkg.sv
// Shared types, constants and the axis dead-zone map for the cursor tracker.
// No dependencies; every module of the block imports this package.
package jct_pkg;

  localparam int unsigned TimeW    = 48;
  localparam int unsigned SampleW  = 12;
  localparam int unsigned PosW     = 16;
  localparam int unsigned StepW    = 5;
  localparam int unsigned PeriodW  = 24;
  localparam int unsigned VisibleW = 28;
  localparam int unsigned LockoutW = 24;
  localparam int unsigned CfgDataW = 28;
  localparam int unsigned CfgIdxW  = 2;

  // dead-zone thresholds on the raw ADC sample
  localparam logic [SampleW-1:0] AxisHighBig   = 12'd3072;
  localparam logic [SampleW-1:0] AxisHighSmall = 12'd2560;
  localparam logic [SampleW-1:0] AxisLowBig    = 12'd512;
  localparam logic [SampleW-1:0] AxisLowSmall  = 12'd1536;

  localparam logic signed [StepW-1:0] StepBig   = 5'sd10;
  localparam logic signed [StepW-1:0] StepSmall = 5'sd3;
  localparam logic signed [StepW-1:0] StepNone  = 5'sd0;

  localparam logic [PeriodW-1:0]  UpdatePeriodRst = 24'd30000;
  localparam logic [VisibleW-1:0] VisibleTimeRst  = 28'd5000000;
  localparam logic [LockoutW-1:0] PressLockoutRst = 24'd200000;
  localparam logic signed [PosW-1:0] CursorRst    = 16'sd120;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UPDATE_PERIOD = 2'd0,
    CFG_VISIBLE_TIME  = 2'd1,
    CFG_PRESS_LOCKOUT = 2'd2
  } cfg_idx_e;

  typedef logic signed [StepW-1:0] step_t;

  typedef struct packed {
    logic [PeriodW-1:0]  update_period;
    logic [VisibleW-1:0] visible_time;
    logic [LockoutW-1:0] press_lockout;
  } cfg_t;

  // classified tick as it travels through the queue
  typedef struct packed {
    logic [TimeW-1:0] time_us;
    step_t            step_x;
    step_t            step_y;
    logic             button;
  } item_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  function automatic step_t axis_step(input logic [SampleW-1:0] s);
    step_t r;
    if (s > AxisHighBig) begin
      r = StepBig;
    end else if (s > AxisHighSmall) begin
      r = StepSmall;
    end else if (s < AxisLowBig) begin
      r = -StepBig;
    end else if (s < AxisLowSmall) begin
      r = -StepSmall;
    end else begin
      r = StepNone;
    end
    return r;
  endfunction

endpackage

>>> design/jct_front.sv
// Input side: takes ticks, maps both axis samples to steps and pushes the
// classified tick into the queue. Depends on jct_pkg.
module jct_front import jct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [TimeW-1:0]   time_us_i,
  input  logic [SampleW-1:0] axis_x_sample_i,
  input  logic [SampleW-1:0] axis_y_sample_i,
  input  logic               button_level_i,
  input  q_status_t          q_status_i,
  output logic               push_o,
  output item_t              push_item_o
);

  logic stall_q;

  // stall_q stays zero, so the port stall is just the queue's full flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_q <= 1'b0;
    end else begin
      stall_q <= 1'b0;
    end
  end

  assign in_stall_o = q_status_i.full | stall_q;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    push_item_o.time_us = time_us_i;
    push_item_o.step_x  = axis_step(axis_x_sample_i);
    push_item_o.step_y  = axis_step(axis_y_sample_i);
    push_item_o.button  = button_level_i;
  end

endmodule

>>> design/jct_queue.sv
// Two-entry queue of classified ticks between the front and back parts.
// Depends on jct_pkg for the entry type.
module jct_queue import jct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     push_item_i,
  input  logic      pop_i,
  output item_t     pop_item_o,
  output q_status_t status_o,
  output logic [1:0] count_o
);

  item_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign pop_item_o         = entry_q[rd_ptr_q];
  assign status_o.not_empty = (count_q != 2'd0);
  assign status_o.full      = (count_q == 2'd2);
  assign count_o            = count_q;

endmodule

>>> design/jct_back.sv
// Back: holds cursor, timer and button state; applies one queued tick per
// cycle unless out stalls; keeps the result register. Depends on jct_pkg.
module jct_back import jct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  q_status_t              q_status_i,
  input  item_t                  item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   redraw_o,
  output logic signed [PosW-1:0] position_x_o,
  output logic signed [PosW-1:0] position_y_o,
  output logic                   shown_o
);

  logic [TimeW-1:0]       last_accept_q, last_accept_d;
  logic [TimeW-1:0]       activity_q, activity_d;
  logic [TimeW-1:0]       last_press_q, last_press_d;
  logic signed [PosW-1:0] cursor_x_q, cursor_x_d;
  logic signed [PosW-1:0] cursor_y_q, cursor_y_d;
  logic                   visible_q, visible_d;
  logic                   prev_button_q, prev_button_d;
  logic                   out_valid_q;
  logic                   redraw_q, redraw_d;

  logic [TimeW-1:0] accept_diff, press_diff, activity_diff;
  logic             accept, moved, press, tick_visible;

  assign pop_o = q_status_i.not_empty & (~out_valid_q | ~out_stall_i);

  // all three gaps are taken against the old state in parallel
  assign accept_diff   = item_i.time_us - last_accept_q;
  assign press_diff    = item_i.time_us - last_press_q;
  assign activity_diff = item_i.time_us - activity_q;

  assign accept = accept_diff >= {{(TimeW-PeriodW){1'b0}}, cfg_i.update_period};
  assign moved  = (item_i.step_x != StepNone) | (item_i.step_y != StepNone);
  assign press  = item_i.button & ~prev_button_q &
                  (press_diff > {{(TimeW-LockoutW){1'b0}}, cfg_i.press_lockout});

  // a restarted timer has age zero
  assign tick_visible = (moved | press) ? (cfg_i.visible_time != '0)
                      : (activity_diff < {{(TimeW-VisibleW){1'b0}}, cfg_i.visible_time});

  always_comb begin
    last_accept_d = last_accept_q;
    activity_d    = activity_q;
    last_press_d  = last_press_q;
    cursor_x_d    = cursor_x_q;
    cursor_y_d    = cursor_y_q;
    visible_d     = visible_q;
    prev_button_d = prev_button_q;
    redraw_d      = 1'b0;
    if (accept) begin
      last_accept_d = item_i.time_us;
      if (moved || press) begin
        activity_d = item_i.time_us;
      end
      if (press) begin
        last_press_d = item_i.time_us;
      end
      visible_d     = tick_visible;
      prev_button_d = item_i.button;
      cursor_x_d    = cursor_x_q + PosW'(item_i.step_x);
      cursor_y_d    = cursor_y_q + PosW'(item_i.step_y);
      redraw_d      = moved | press | (tick_visible != visible_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_accept_q <= '0;
      activity_q    <= '0;
      last_press_q  <= '0;
      cursor_x_q    <= CursorRst;
      cursor_y_q    <= CursorRst;
      visible_q     <= 1'b1;
      prev_button_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        last_accept_q <= last_accept_d;
        activity_q    <= activity_d;
        last_press_q  <= last_press_d;
        cursor_x_q    <= cursor_x_d;
        cursor_y_q    <= cursor_y_d;
        visible_q     <= visible_d;
        prev_button_q <= prev_button_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      redraw_q <= redraw_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign redraw_o     = redraw_q;
  assign position_x_o = cursor_x_q;
  assign position_y_o = cursor_y_q;
  assign shown_o      = visible_q;

endmodule

>>> design/joystick_cursor_tracker.sv
// Top level of the joystick cursor tracker: configuration registers, front
// classifier, tick queue and back state unit. Depends on jct_pkg.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o   time_us, axis_x/y_sample, button_level
//   out      output     out_valid_o / out_stall_i redraw, position_x/y, shown
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One tick is taken per cycle while in_stall_o is low; a taken tick is written
// into the queue, then applied to the back unit's state registers, which hold the result.
// The back unit compares 48-bit time gaps and applies one tick per clock unless out stalls.
// Reset (rst_ni low) clears the queue, the cursor state and the registers to
// their defaults. An output stall fills the two-entry queue, then stalls input.
module joystick_cursor_tracker import jct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [TimeW-1:0]       time_us_i,
  input  logic [SampleW-1:0]     axis_x_sample_i,
  input  logic [SampleW-1:0]     axis_y_sample_i,
  input  logic                   button_level_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   redraw_o,
  output logic signed [PosW-1:0] position_x_o,
  output logic signed [PosW-1:0] position_y_o,
  output logic                   shown_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  cfg_t       cfg_q;
  q_status_t  q_status;
  item_t      push_item, pop_item;
  logic       push, pop;
  logic [1:0] q_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.update_period <= UpdatePeriodRst;
      cfg_q.visible_time  <= VisibleTimeRst;
      cfg_q.press_lockout <= PressLockoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_UPDATE_PERIOD: cfg_q.update_period <= cfg_data_i[PeriodW-1:0];
        CFG_VISIBLE_TIME:  cfg_q.visible_time  <= cfg_data_i[VisibleW-1:0];
        CFG_PRESS_LOCKOUT: cfg_q.press_lockout <= cfg_data_i[LockoutW-1:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  jct_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .time_us_i       (time_us_i),
    .axis_x_sample_i (axis_x_sample_i),
    .axis_y_sample_i (axis_y_sample_i),
    .button_level_i  (button_level_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .push_item_o     (push_item)
  );

  jct_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status),
    .count_o     (q_count)
  );

  jct_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_status_i   (q_status),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .redraw_o     (redraw_o),
    .position_x_o (position_x_o),
    .position_y_o (position_y_o),
    .shown_o      (shown_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count != 2'd3)
    else $error("tick queue count beyond its depth");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (q_count != 2'd0))
    else $error("accepted tick missing from the queue");

  a_pop_feeds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o)
    else $error("applied tick produced no result");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count == 2'd2) |-> in_stall_o)
    else $error("input taken while the queue is full");

endmodule

>>> tb/sv/cursor_check_pkg.sv
`timescale 1ns / 100ps
// Cursor tracker scoreboard: a bit-true predictor of the tracker state and
// a queue of expected results. Depends on jct_pkg for widths, codes and resets.
package cursor_check_pkg;
  import jct_pkg::*;

  localparam logic [PosW-1:0] BigDelta   = 16'd10;
  localparam logic [PosW-1:0] SmallDelta = 16'd3;

  typedef struct packed {
    logic            redraw;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic            shown;
  } cursor_view_t;

  class cursor_scoreboard;
    logic [PeriodW-1:0]  update_period;
    logic [VisibleW-1:0] visible_time;
    logic [LockoutW-1:0] press_lockout;
    logic [TimeW-1:0]    last_tick_time;
    logic [TimeW-1:0]    activity_time;
    logic [TimeW-1:0]    last_press_time;
    logic [PosW-1:0]     cursor_x;
    logic [PosW-1:0]     cursor_y;
    logic                visible;
    logic                button_prev;
    cursor_view_t        expected_cursor_q[$];
    int unsigned         mismatches;
    int unsigned         results_checked;

    function new();
      update_period   = UpdatePeriodRst;
      visible_time    = VisibleTimeRst;
      press_lockout   = PressLockoutRst;
      last_tick_time  = '0;
      activity_time   = '0;
      last_press_time = '0;
      cursor_x        = CursorRst;
      cursor_y        = CursorRst;
      visible         = 1'b1;
      button_prev     = 1'b0;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function void write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
      case (idx)
        CFG_UPDATE_PERIOD: update_period = data[PeriodW-1:0];
        CFG_VISIBLE_TIME:  visible_time  = data[VisibleW-1:0];
        CFG_PRESS_LOCKOUT: press_lockout = data[LockoutW-1:0];
        default: ;
      endcase
    endfunction

    // dead-zone map to a 16-bit wrapping step
    function logic [PosW-1:0] axis_delta(input logic [SampleW-1:0] s);
      if (s > AxisHighBig) return BigDelta;
      if (s > AxisHighSmall) return SmallDelta;
      if (s < AxisLowBig) return -BigDelta;
      if (s < AxisLowSmall) return -SmallDelta;
      return '0;
    endfunction

    function void note_tick(input logic [TimeW-1:0] t, input logic [SampleW-1:0] sx,
                            input logic [SampleW-1:0] sy, input logic button);
      logic [TimeW-1:0] gap;
      logic [PosW-1:0]  dx;
      logic [PosW-1:0]  dy;
      logic             redraw;
      logic             tick_visible;
      cursor_view_t     view;
      redraw = 1'b0;
      gap = t - last_tick_time;
      if (gap >= update_period) begin
        dx = axis_delta(sx);
        dy = axis_delta(sy);
        last_tick_time = t;
        if (dx != '0 || dy != '0) begin
          activity_time = t;
          redraw = 1'b1;
        end
        gap = t - last_press_time;
        if (button && !button_prev && gap > press_lockout) begin
          last_press_time = t;
          activity_time = t;
          redraw = 1'b1;
        end
        gap = t - activity_time;
        tick_visible = gap < visible_time;
        if (tick_visible != visible) redraw = 1'b1;
        visible = tick_visible;
        button_prev = button;
        cursor_x = cursor_x + dx;
        cursor_y = cursor_y + dy;
      end
      view.redraw = redraw;
      view.pos_x  = cursor_x;
      view.pos_y  = cursor_y;
      view.shown  = visible;
      expected_cursor_q.push_back(view);
    endfunction

    function void flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_cursor(input logic redraw, input logic [PosW-1:0] pos_x,
                               input logic [PosW-1:0] pos_y, input logic shown);
      cursor_view_t want;
      results_checked++;
      if (expected_cursor_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with no tick pending", results_checked));
        return;
      end
      want = expected_cursor_q.pop_front();
      if (want.redraw !== redraw)
        flag_mismatch($sformatf("result %0d redraw: expected %0b, got %0b",
                                results_checked, want.redraw, redraw));
      if (want.pos_x !== pos_x)
        flag_mismatch($sformatf("result %0d position_x: expected %0d, got %0d",
                                results_checked, $signed(want.pos_x), $signed(pos_x)));
      if (want.pos_y !== pos_y)
        flag_mismatch($sformatf("result %0d position_y: expected %0d, got %0d",
                                results_checked, $signed(want.pos_y), $signed(pos_y)));
      if (want.shown !== shown)
        flag_mismatch($sformatf("result %0d shown: expected %0b, got %0b",
                                results_checked, want.shown, shown));
    endfunction
  endclass

endpackage

>>> tb/sv/tb_joystick_cursor_tracker.sv
`timescale 1ns / 100ps
// Top of the cursor tracker testbench: clock, reset, request drivers, output
// stall and register writes. Depends on jct_pkg, cursor_check_pkg and the block.
module tb_joystick_cursor_tracker;
  import jct_pkg::*;
  import cursor_check_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [TimeW-1:0]       time_us_i;
  logic [SampleW-1:0]     axis_x_sample_i;
  logic [SampleW-1:0]     axis_y_sample_i;
  logic                   button_level_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   redraw_o;
  logic signed [PosW-1:0] position_x_o;
  logic signed [PosW-1:0] position_y_o;
  logic                   shown_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i;
  logic [CfgDataW-1:0]    cfg_data_i;

  cursor_scoreboard sb;
  bit               tick_taken;
  bit               cfg_taken;
  int unsigned      cycle_count;
  logic [TimeW-1:0] t_now;
  logic             button;

  joystick_cursor_tracker dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    tick_taken = in_valid_i && !in_stall_o;
    cfg_taken  = cfg_valid_i && cfg_ready_o;
    if (tick_taken) sb.note_tick(time_us_i, axis_x_sample_i, axis_y_sample_i, button_level_i);
    if (cfg_taken) sb.write_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
    if (out_valid_o && !out_stall_i) sb.check_cursor(redraw_o, position_x_o, position_y_o, shown_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    forever begin
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(50, 200)) @(negedge clk_i);
      end else begin
        n = gap_len();
        if (n != 0) begin
          out_stall_i = 1'b1;
          repeat (n) @(negedge clk_i);
          out_stall_i = 1'b0;
        end
      end
    end
  end

  function automatic logic [SampleW-1:0] pick_sample();
    int unsigned       r;
    logic [SampleW-1:0] base;
    r = $urandom_range(0, 99);
    if (r < 40) return SampleW'($urandom_range(0, 4095));
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: base = AxisHighBig;
        1: base = AxisHighSmall;
        2: base = AxisLowBig;
        default: base = AxisLowSmall;
      endcase
      return base + SampleW'($urandom_range(0, 4)) - 12'd2;
    end
    if (r < 90) return SampleW'($urandom_range(AxisLowSmall, AxisHighSmall));
    return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
  endfunction

  task automatic send_tick(input logic [TimeW-1:0] t, input logic [SampleW-1:0] sx,
                           input logic [SampleW-1:0] sy, input logic btn, input bit no_gap);
    int unsigned idle;
    idle = no_gap ? 0 : gap_len();
    if (idle != 0) begin
      in_valid_i = 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    time_us_i       = t;
    axis_x_sample_i = sx;
    axis_y_sample_i = sy;
    button_level_i  = btn;
    do @(negedge clk_i); while (!tick_taken);
  endtask

  // drop valid and let every pending result and the pipeline drain
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.expected_cursor_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i = 1'b0;
  endtask

  task automatic program_regs(input logic [PeriodW-1:0] period,
                              input logic [VisibleW-1:0] vis,
                              input logic [LockoutW-1:0] lockout);
    drain();
    write_cfg(CFG_UPDATE_PERIOD, CfgDataW'(period));
    write_cfg(CFG_VISIBLE_TIME, CfgDataW'(vis));
    write_cfg(CFG_PRESS_LOCKOUT, CfgDataW'(lockout));
  endtask

  task automatic run_random(input int unsigned count, input int unsigned still_pct,
                            input bit drift);
    logic [TimeW-1:0]   step;
    logic [SampleW-1:0] sx;
    logic [SampleW-1:0] sy;
    int unsigned        r;
    bit                 burst;
    burst = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      // mostly ticks just past the update period, some early, some far off
      r = $urandom_range(0, 99);
      if (r < 12)
        step = (sb.update_period == '0) ? '0 :
               TimeW'($urandom_range(0, sb.update_period - 1));
      else if (r < 80)
        step = TimeW'(sb.update_period) +
               TimeW'($urandom_range(0, sb.update_period / 4 + 3));
      else if (r < 92)
        step = TimeW'($urandom_range(0, 2 * sb.visible_time + 2));
      else
        step = TimeW'({$urandom, $urandom});
      t_now = t_now + step;
      if (drift) begin
        sx = ($urandom_range(0, 99) < 96) ? SampleW'($urandom_range(3073, 4095)) : pick_sample();
        sy = ($urandom_range(0, 99) < 96) ? SampleW'($urandom_range(0, 511)) : pick_sample();
      end else if ($urandom_range(0, 99) < still_pct) begin
        sx = SampleW'($urandom_range(AxisLowSmall, AxisHighSmall));
        sy = SampleW'($urandom_range(AxisLowSmall, AxisHighSmall));
      end else begin
        sx = pick_sample();
        sy = pick_sample();
      end
      if ($urandom_range(0, 99) < 35) button = ~button;
      send_tick(t_now, sx, sy, button, burst);
    end
  endtask

  initial begin
    sb              = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    time_us_i       = '0;
    axis_x_sample_i = '0;
    axis_y_sample_i = '0;
    button_level_i  = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_UPDATE_PERIOD;
    cfg_data_i      = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // early ticks before the first update period
    send_tick(48'd0, 12'd4095, 12'd0, 1'b1, 1'b0);
    send_tick(48'd29999, 12'd4095, 12'd0, 1'b1, 1'b0);
    // dead-zone edges on both axes
    send_tick(48'd30000, 12'd3073, 12'd511, 1'b0, 1'b0);
    send_tick(48'd60000, 12'd3072, 12'd512, 1'b0, 1'b0);
    send_tick(48'd90000, 12'd2561, 12'd1535, 1'b0, 1'b0);
    send_tick(48'd120000, 12'd2560, 12'd1536, 1'b0, 1'b0);
    // press inside the lockout, then one outside it
    send_tick(48'd150000, 12'd2048, 12'd2048, 1'b1, 1'b0);
    send_tick(48'd180000, 12'd2048, 12'd2048, 1'b0, 1'b0);
    send_tick(48'd250000, 12'd2048, 12'd2048, 1'b1, 1'b0);
    // ignored tick must not sample the button
    send_tick(48'd260000, 12'd2048, 12'd2048, 1'b0, 1'b0);
    send_tick(48'd290000, 12'd2048, 12'd2048, 1'b1, 1'b0);
    // visibility timeout, then movement brings the cursor back
    send_tick(48'd5300000, 12'd2048, 12'd2048, 1'b0, 1'b0);
    send_tick(48'd5330000, 12'd2048, 12'd2048, 1'b0, 1'b0);
    send_tick(48'd5360000, 12'd0, 12'd4095, 1'b0, 1'b0);
    // timestamp wrap
    send_tick(48'hFFFF_FFFF_FFF0, 12'd1000, 12'd3000, 1'b0, 1'b0);
    send_tick(48'd30000, 12'd4095, 12'd0, 1'b1, 1'b0);
    send_tick(48'd30001, 12'd4095, 12'd0, 1'b0, 1'b0);
    send_tick(48'hAAAA_AAAA_AAAA, 12'hAAA, 12'h555, 1'b0, 1'b0);
    send_tick(48'h5555_5555_5555, 12'h555, 12'hAAA, 1'b1, 1'b0);
    t_now  = 48'h5555_5555_5555;
    button = 1'b1;

    run_random(200, 30, 1'b0);
    program_regs('0, 28'd40, '0);
    run_random(200, 70, 1'b0);
    program_regs('1, '1, '1);
    t_now = 48'hFFFF_8000_0000;
    run_random(150, 30, 1'b0);
    program_regs(24'd500, '0, 24'd50);
    run_random(150, 30, 1'b0);
    program_regs(PeriodW'($urandom_range(1, 2000)), VisibleW'($urandom_range(1, 30000)),
                 LockoutW'($urandom_range(1, 3000)));
    run_random(200, 50, 1'b0);
    // drive both axes hard in one direction for a long run
    program_regs('0, VisibleW'($urandom_range(100, 1000)), 24'd10);
    run_random(500, 0, 1'b1);
    program_regs(UpdatePeriodRst, VisibleTimeRst, PressLockoutRst);
    run_random(180, 40, 1'b0);

    drain();
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
